FILE: hw/rtl/sm4_block_cipher_defines.svh
// assertion macros for the sm4 block cipher
`ifndef SM4_BLOCK_CIPHER_DEFINES_SVH
`define SM4_BLOCK_CIPHER_DEFINES_SVH

`ifndef ASSERT_OFF
`define SM4_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("sm4 assertion failed");
`define SM4_ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("sm4 forbidden condition seen");
`else
`define SM4_ASSERT(label, prop)
`define SM4_ASSERT_NEVER(label, cond)
`endif

`endif

FILE: hw/rtl/sm4_pkg.sv
package sm4_pkg;

  localparam int RoundCount = 32;
  localparam int RoundIdxW  = $clog2(RoundCount);
  localparam int CfgIdxW    = 2;
  localparam int CfgDataW   = 64;

  typedef struct packed {
    logic [63:0] block_high;
    logic [63:0] block_low;
  } in_item_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
  } out_item_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_KEY_HIGH = 2'd0,
    CFG_KEY_LOW  = 2'd1,
    CFG_DECRYPT  = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXPAND,
    ST_PREP,
    ST_CIPHER
  } state_e;

  localparam logic [31:0] FK0 = 32'ha3b1bac6;
  localparam logic [31:0] FK1 = 32'h56aa3350;
  localparam logic [31:0] FK2 = 32'h677d9197;
  localparam logic [31:0] FK3 = 32'hb27022dc;

  localparam logic [7:0] SBOX [256] = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
  };

  function automatic logic [31:0] sub_word(logic [31:0] v);
    return {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
  endfunction

  // byte j of ck is (4i + j) * 7 mod 256
  function automatic logic [31:0] ck_word(logic [RoundIdxW-1:0] i);
    logic [7:0] base;
    logic [7:0] b0, b1, b2, b3;
    base = {1'b0, i, 2'b00};
    b0 = 8'(base * 8'd7);
    b1 = 8'((base + 8'd1) * 8'd7);
    b2 = 8'((base + 8'd2) * 8'd7);
    b3 = 8'((base + 8'd3) * 8'd7);
    return {b0, b1, b2, b3};
  endfunction

endpackage

FILE: hw/rtl/sm4_rk_mem.sv
module sm4_rk_mem (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [sm4_pkg::RoundIdxW-1:0] waddr_i,
  input  logic [31:0]                   wdata_i,
  input  logic                          re_i,
  input  logic [sm4_pkg::RoundIdxW-1:0] raddr_i,
  output logic [31:0]                   rdata_o
);
  import sm4_pkg::*;

  logic [31:0] mem_q [RoundCount];
  logic [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/sm4_round.sv
module sm4_round_core (
  input  logic [3:0][31:0] words_i,
  input  logic [31:0]      rk_i,
  input  logic             key_sched_i,
  output logic [31:0]      word_o
);
  import sm4_pkg::*;

  logic [31:0] sub;
  logic [31:0] lin;

  assign sub = sub_word(words_i[1] ^ words_i[2] ^ words_i[3] ^ rk_i);

  // key schedule uses the lighter linear layer
  always_comb begin
    if (key_sched_i) begin
      lin = sub ^ {sub[18:0], sub[31:19]} ^ {sub[8:0], sub[31:9]};
    end else begin
      lin = sub ^ {sub[29:0], sub[31:30]} ^ {sub[21:0], sub[31:22]}
                ^ {sub[13:0], sub[31:14]} ^ {sub[7:0], sub[31:8]};
    end
  end

  assign word_o = words_i[0] ^ lin;

endmodule

FILE: hw/rtl/sm4_block_cipher.sv
// SM4 block cipher, 128-bit key and block. The key words and the direction are written through
// the configuration port; the user must write them only while the block is idle, as the block
// itself does not enforce it. Any write to a known register invalidates the round keys. The
// first block after reset or after such a write first runs the key schedule through the shared
// round unit, writing one round key per cycle into a 32-entry key memory (reversed for
// decryption), then prefetches the first round key. Every block then runs its rounds, one per
// round key read from that memory. A new block is accepted only once the previous one has left
// its last round, so blocks do not overlap. The result sits in an output register; the last
// round holds until a previous result has been taken.
`include "sm4_block_cipher_defines.svh"

module sm4_block_cipher (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sm4_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [sm4_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  sm4_pkg::in_item_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output sm4_pkg::out_item_t            out_data_o
);
  import sm4_pkg::*;

  state_e                 state_q, state_d;
  logic [RoundIdxW-1:0]   cnt_q, cnt_d;
  logic                   keys_ready_q, keys_ready_d;
  logic [63:0]            key_high_q, key_low_q;
  logic                   decrypt_q;
  logic [3:0][31:0]       x_q, k_q;
  logic                   out_valid_q;
  out_item_t              out_data_q;

  logic                   in_accept;
  logic                   cfg_hit;
  logic                   last_round;
  logic                   out_free;
  logic                   step;
  logic                   expanding;

  logic [3:0][31:0]       rnd_words;
  logic [31:0]            rnd_rk;
  logic [31:0]            rnd_new;

  logic                   rk_we, rk_re;
  logic [RoundIdxW-1:0]   rk_waddr, rk_raddr;
  logic [31:0]            rk_rdata;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;
  assign cfg_hit    = cfg_we_i && (cfg_index_i == CFG_KEY_HIGH || cfg_index_i == CFG_KEY_LOW ||
                                   cfg_index_i == CFG_DECRYPT);
  assign last_round = (cnt_q == RoundIdxW'(RoundCount - 1));
  assign out_free   = !out_valid_q || out_ready_i;
  assign step       = (state_q == ST_CIPHER) && (!last_round || out_free);
  assign expanding  = (state_q == ST_EXPAND);

  // shared round unit: key schedule or data round
  assign rnd_words = expanding ? k_q : x_q;
  assign rnd_rk    = expanding ? ck_word(cnt_q) : rk_rdata;

  sm4_round_core u_round (
    .words_i     (rnd_words),
    .rk_i        (rnd_rk),
    .key_sched_i (expanding),
    .word_o      (rnd_new)
  );

  assign rk_we    = expanding;
  assign rk_waddr = decrypt_q ? (RoundIdxW'(RoundCount - 1) - cnt_q) : cnt_q;

  // round key i+1 is fetched while round i runs
  always_comb begin
    rk_re    = 1'b0;
    rk_raddr = '0;
    case (state_q)
      ST_IDLE: begin
        rk_re = in_accept && keys_ready_q;
      end
      ST_PREP: begin
        rk_re = 1'b1;
      end
      ST_CIPHER: begin
        rk_re    = step;
        rk_raddr = cnt_q + RoundIdxW'(1);
      end
      default: begin
        rk_re = 1'b0;
      end
    endcase
  end

  sm4_rk_mem u_rk_mem (
    .clk_i   (clk_i),
    .we_i    (rk_we),
    .waddr_i (rk_waddr),
    .wdata_i (rnd_new),
    .re_i    (rk_re),
    .raddr_i (rk_raddr),
    .rdata_o (rk_rdata)
  );

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    keys_ready_d = keys_ready_q;
    case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (in_accept) begin
          state_d = keys_ready_q ? ST_CIPHER : ST_EXPAND;
        end
      end
      ST_EXPAND: begin
        cnt_d = cnt_q + RoundIdxW'(1);
        if (last_round) begin
          state_d      = ST_PREP;
          keys_ready_d = 1'b1;
        end
      end
      ST_PREP: begin
        state_d = ST_CIPHER;
        cnt_d   = '0;
      end
      ST_CIPHER: begin
        if (step) begin
          cnt_d = cnt_q + RoundIdxW'(1);
          if (last_round) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    if (cfg_hit) begin
      keys_ready_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      keys_ready_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      keys_ready_q <= keys_ready_d;
      if (step && last_round) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
      decrypt_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_KEY_HIGH: key_high_q <= cfg_wdata_i;
        CFG_KEY_LOW:  key_low_q  <= cfg_wdata_i;
        CFG_DECRYPT:  decrypt_q  <= cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      x_q <= {in_data_i.block_low[31:0], in_data_i.block_low[63:32],
              in_data_i.block_high[31:0], in_data_i.block_high[63:32]};
      k_q <= {key_low_q[31:0] ^ FK3, key_low_q[63:32] ^ FK2,
              key_high_q[31:0] ^ FK1, key_high_q[63:32] ^ FK0};
    end else begin
      if (step) begin
        x_q <= {rnd_new, x_q[3], x_q[2], x_q[1]};
      end
      if (expanding) begin
        k_q <= {rnd_new, k_q[3], k_q[2], k_q[1]};
      end
    end
  end

  // final words leave in reversed order
  always_ff @(posedge clk_i) begin
    if (step && last_round) begin
      out_data_q.result_high <= {rnd_new, x_q[3]};
      out_data_q.result_low  <= {x_q[2], x_q[1]};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `SM4_ASSERT(a_cfg_clears_keys, cfg_hit |=> !keys_ready_q)
  `SM4_ASSERT(a_expand_then_prep, (expanding && last_round) |=> (state_q == ST_PREP))
  `SM4_ASSERT(a_last_round_yields_result, (step && last_round) |=> out_valid_q)
  `SM4_ASSERT_NEVER(a_no_rk_collision, rk_we && rk_re && (rk_waddr == rk_raddr))

endmodule
